FILE: rtl/epsm_pkg.sv
package epsm_pkg;

	localparam int unsigned PADDR_W = 3;

	localparam logic REG_RPM_GAIN   = 1'b0;
	localparam logic REG_ANGLE_GAIN = 1'b1;

	localparam logic [23:0] RPM_GAIN_RST   = 24'd65536;
	localparam logic [31:0] ANGLE_GAIN_RST = 32'd2304000;

	localparam logic FUNC_EDGE = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	typedef struct packed {
		logic [23:0] rpm_gain;
		logic [31:0] angle_gain;
	} gain_t;

	typedef struct packed {
		logic        tick;
		logic [31:0] pos;
		logic [31:0] delta;
	} cnt_beat_t;

	typedef struct packed {
		logic        tick;
		logic [31:0] pos;
		logic        spd_neg;
		logic [47:0] spd_mag;
		logic        ang_neg;
		logic [47:0] ang_mag;
	} rnd_beat_t;

endpackage

FILE: rtl/epsm_in_if.sv
interface epsm_in_if;
	logic valid;
	logic ready;
	logic func;
	logic b_level;

	modport source (output valid, output func, output b_level, input ready);
	modport sink (input valid, input func, input b_level, output ready);
endinterface

FILE: rtl/epsm_out_if.sv
interface epsm_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] position;
	logic signed [31:0] speed_rpm;
	logic signed [47:0] angle_centideg;

	modport source (output valid, output position, output speed_rpm, output angle_centideg,
		input ready);
	modport sink (input valid, input position, input speed_rpm, input angle_centideg,
		output ready);
endinterface

FILE: rtl/epsm_cfg.sv
module epsm_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [epsm_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output epsm_pkg::gain_t               gains
);
	import epsm_pkg::*;

	logic [23:0] rpm_gain_q;
	logic [31:0] angle_gain_q;
	logic        wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpm_gain_q   <= RPM_GAIN_RST;
			angle_gain_q <= ANGLE_GAIN_RST;
		end else if (wr) begin
			unique case (paddr[2])
				REG_RPM_GAIN:   rpm_gain_q   <= pwdata[23:0];
				REG_ANGLE_GAIN: angle_gain_q <= pwdata;
				default:        ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_RPM_GAIN:   prdata = {8'd0, rpm_gain_q};
			REG_ANGLE_GAIN: prdata = angle_gain_q;
			default:        prdata = 32'd0;
		endcase
	end

	assign gains.rpm_gain   = rpm_gain_q;
	assign gains.angle_gain = angle_gain_q;
endmodule

FILE: rtl/epsm_count.sv
module epsm_count (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  func,
	input  logic                  b_level,
	output logic                  in_ready,
	output logic                  v_s1,
	output epsm_pkg::cnt_beat_t   beat_s1,
	input  logic                  dn_ready
);
	import epsm_pkg::*;

	logic [31:0] pos_q;
	logic [31:0] last_q;
	logic [31:0] pos_nxt;
	logic        en;
	logic        acc;

	assign en = !v_s1 || dn_ready;
	assign acc = in_valid && en;
	assign in_ready = en;

	always_comb begin
		if (func == FUNC_TICK) begin
			pos_nxt = pos_q;
		end else if (b_level) begin
			pos_nxt = pos_q - 32'd1;
		end else begin
			pos_nxt = pos_q + 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= 32'd0;
			last_q <= 32'd0;
			v_s1   <= 1'b0;
		end else begin
			if (en) begin
				v_s1 <= in_valid;
			end
			if (acc) begin
				pos_q <= pos_nxt;
				if (func == FUNC_TICK) begin
					last_q <= pos_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			beat_s1.tick  <= func;
			beat_s1.pos   <= pos_nxt;
			beat_s1.delta <= pos_q - last_q;
		end
	end
endmodule

FILE: rtl/epsm_mul.sv
module epsm_mul (
	input  logic                  clk,
	input  logic                  arst_n,
	input  epsm_pkg::gain_t       gains,
	input  logic                  v_s1,
	input  epsm_pkg::cnt_beat_t   beat_s1,
	output logic                  up_ready,
	output logic                  v_s4,
	output epsm_pkg::rnd_beat_t   beat_s4,
	input  logic                  dn_ready
);
	import epsm_pkg::*;

	typedef struct packed {
		logic        tick;
		logic [31:0] pos;
		logic        pos_neg;
		logic [31:0] pos_mag;
		logic        dlt_neg;
		logic [31:0] dlt_mag;
	} mag_beat_t;

	typedef struct packed {
		logic        tick;
		logic [31:0] pos;
		logic        pos_neg;
		logic [63:0] ang_prod;
		logic        dlt_neg;
		logic [55:0] spd_prod;
	} prod_beat_t;

	mag_beat_t  beat_s2;
	prod_beat_t beat_s3;
	logic       v_s2;
	logic       v_s3;
	logic       en2;
	logic       en3;
	logic       en4;
	logic [55:0] spd_rnd;
	logic [63:0] ang_rnd;

	assign en4 = !v_s4 || dn_ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign up_ready = en2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// magnitudes
	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			beat_s2.tick    <= beat_s1.tick;
			beat_s2.pos     <= beat_s1.pos;
			beat_s2.pos_neg <= beat_s1.pos[31];
			beat_s2.pos_mag <= beat_s1.pos[31] ? (~beat_s1.pos + 32'd1) : beat_s1.pos;
			beat_s2.dlt_neg <= beat_s1.delta[31];
			beat_s2.dlt_mag <= beat_s1.delta[31] ? (~beat_s1.delta + 32'd1) : beat_s1.delta;
		end
	end

	// products
	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			beat_s3.tick     <= beat_s2.tick;
			beat_s3.pos      <= beat_s2.pos;
			beat_s3.pos_neg  <= beat_s2.pos_neg;
			beat_s3.ang_prod <= 64'(beat_s2.pos_mag) * 64'(gains.angle_gain);
			beat_s3.dlt_neg  <= beat_s2.dlt_neg;
			beat_s3.spd_prod <= 56'(beat_s2.dlt_mag) * 56'(gains.rpm_gain);
		end
	end

	// round half away from zero on the magnitudes
	assign spd_rnd = beat_s3.spd_prod + 56'd128;
	assign ang_rnd = beat_s3.ang_prod + 64'd32768;

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			beat_s4.tick    <= beat_s3.tick;
			beat_s4.pos     <= beat_s3.pos;
			beat_s4.spd_neg <= beat_s3.dlt_neg;
			beat_s4.spd_mag <= spd_rnd[55:8];
			beat_s4.ang_neg <= beat_s3.pos_neg;
			beat_s4.ang_mag <= ang_rnd[63:16];
		end
	end
endmodule

FILE: rtl/epsm_out.sv
module epsm_out (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  v_s4,
	input  epsm_pkg::rnd_beat_t   beat_s4,
	output logic                  up_ready,
	output logic                  v_s5,
	output logic [31:0]           pos_s5,
	output logic [31:0]           spd_s5,
	output logic [47:0]           ang_s5,
	input  logic                  dn_ready
);
	import epsm_pkg::*;

	logic [31:0] speed_q;
	logic [31:0] spd_sat;
	logic [31:0] spd_cur;
	logic [47:0] ang_val;
	logic        en5;
	logic        adv;

	assign en5 = !v_s5 || dn_ready;
	assign up_ready = en5;
	assign adv = en5 && v_s4;

	always_comb begin
		if (beat_s4.spd_neg) begin
			if (beat_s4.spd_mag > 48'h0000_8000_0000) begin
				spd_sat = 32'h8000_0000;
			end else begin
				spd_sat = ~beat_s4.spd_mag[31:0] + 32'd1;
			end
		end else if (beat_s4.spd_mag > 48'h0000_7FFF_FFFF) begin
			spd_sat = 32'h7FFF_FFFF;
		end else begin
			spd_sat = beat_s4.spd_mag[31:0];
		end
	end

	assign spd_cur = beat_s4.tick ? spd_sat : speed_q;
	assign ang_val = beat_s4.ang_neg ? (~beat_s4.ang_mag + 48'd1) : beat_s4.ang_mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= 32'd0;
			v_s5    <= 1'b0;
		end else begin
			if (en5) v_s5 <= v_s4;
			if (adv && beat_s4.tick) speed_q <= spd_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s5 <= beat_s4.pos;
			spd_s5 <= spd_cur;
			ang_s5 <= ang_val;
		end
	end
endmodule

FILE: rtl/encoder_position_speed_meter.sv
// channel  | dir | beat fields                              | handshake
// evt      | in  | func, b_level                            | valid/ready
// res      | out | position, speed_rpm, angle_centideg      | valid/ready
// apb      | in  | rpm_gain at 0x0, angle_gain at 0x4       | psel/penable, pready tied high
//
// one event per clock sustained while res.ready holds; each taken event yields one result after passing every stage
// the five-stage pipe is count, magnitude, multiply, round, sign/saturate
// each stage holds its beat while downstream stalls and fills bubbles when it can
// reset clears position, last tick position, held speed and all valid flags
module encoder_position_speed_meter (
	input  logic                          clk,
	input  logic                          arst_n,
	epsm_in_if.sink                       evt,
	epsm_out_if.source                    res,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [epsm_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import epsm_pkg::*;

	gain_t       gains;
	logic        v_s1;
	cnt_beat_t   beat_s1;
	logic        rdy_s1;
	logic        v_s4;
	rnd_beat_t   beat_s4;
	logic        rdy_s4;
	logic [31:0] pos_s5;
	logic [31:0] spd_s5;
	logic [47:0] ang_s5;

	epsm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.gains   (gains)
	);

	epsm_count u_count (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (evt.valid),
		.func     (evt.func),
		.b_level  (evt.b_level),
		.in_ready (evt.ready),
		.v_s1     (v_s1),
		.beat_s1  (beat_s1),
		.dn_ready (rdy_s1)
	);

	epsm_mul u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.gains    (gains),
		.v_s1     (v_s1),
		.beat_s1  (beat_s1),
		.up_ready (rdy_s1),
		.v_s4     (v_s4),
		.beat_s4  (beat_s4),
		.dn_ready (rdy_s4)
	);

	epsm_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.v_s4     (v_s4),
		.beat_s4  (beat_s4),
		.up_ready (rdy_s4),
		.v_s5     (res.valid),
		.pos_s5   (pos_s5),
		.spd_s5   (spd_s5),
		.ang_s5   (ang_s5),
		.dn_ready (res.ready)
	);

	assign res.position       = $signed(pos_s5);
	assign res.speed_rpm      = $signed(spd_s5);
	assign res.angle_centideg = $signed(ang_s5);
endmodule

FILE: rtl/epsm_chk.sv
module epsm_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        evt_valid,
	input logic        evt_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [31:0] res_position,
	input logic [31:0] res_speed_rpm,
	input logic [47:0] res_angle_centideg,
	input logic        pready
);
	logic [3:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc = evt_valid && evt_ready;
	assign out_acc = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 4'd0;
		end else begin
			pend_q <= pend_q + {3'd0, in_acc} - {3'd0, out_acc};
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_position)
			&& $stable(res_speed_rpm) && $stable(res_angle_centideg))
		else $error("result beat changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pend_q != 4'd0 && pend_q <= 4'd5)
		else $error("result beat without a matching event");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		res_ready |-> evt_ready)
		else $error("event port stalled while results drain");

	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_position[31] || !res_angle_centideg[47])
			&& (!res_position[31] || res_angle_centideg[47] || res_angle_centideg == 48'd0))
		else $error("angle sign disagrees with position");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");
endmodule

bind encoder_position_speed_meter epsm_chk u_chk (
	.clk                (clk),
	.arst_n             (arst_n),
	.evt_valid          (evt.valid),
	.evt_ready          (evt.ready),
	.res_valid          (res.valid),
	.res_ready          (res.ready),
	.res_position       (res.position),
	.res_speed_rpm      (res.speed_rpm),
	.res_angle_centideg (res.angle_centideg),
	.pready             (pready)
);

FILE: bench/tb_encoder_position_speed_meter.sv
`timescale 1ns / 1ps

module tb_encoder_position_speed_meter;
	import epsm_pkg::*;

	typedef struct packed {
		logic func;
		logic b_level;
	} encoder_event_t;

	typedef struct packed {
		logic signed [31:0] position;
		logic signed [31:0] speed_rpm;
		logic signed [47:0] angle_centideg;
	} meter_reading_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	epsm_in_if  evt ();
	epsm_out_if res ();

	encoder_position_speed_meter uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.evt     (evt),
		.res     (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// shadow of the meter
	logic [23:0] rpm_gain_cfg = RPM_GAIN_RST;
	logic [31:0] angle_gain_cfg = ANGLE_GAIN_RST;
	logic [31:0] count_now = '0;
	logic [31:0] count_at_tick = '0;
	logic [31:0] speed_q8 = '0;

	encoder_event_t pending_events[$];
	meter_reading_t readings_due[$];

	bit          evt_taken = 1'b0;
	bit          idling = 1'b1;
	int unsigned send_gap = 0;
	int unsigned sink_gap = 0;
	int unsigned hold_off = 0;
	int unsigned errors = 0;
	int unsigned events_taken = 0;
	int unsigned readings_checked = 0;
	int unsigned gain_settings = 1;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] magnitude(input logic [31:0] v);
		return v[31] ? ~v + 32'd1 : v;
	endfunction

	function automatic logic [31:0] rpm_from_delta(input logic [31:0] delta);
		logic [63:0] m;
		m = ({32'd0, magnitude(delta)} * {40'd0, rpm_gain_cfg} + 64'd128) >> 8;
		if (delta[31]) begin
			if (m > 64'h8000_0000)
				m = 64'h8000_0000;
			return ~m[31:0] + 32'd1;
		end
		return (m > 64'h7fff_ffff) ? 32'h7fff_ffff : m[31:0];
	endfunction

	function automatic logic [47:0] centideg_from_count(input logic [31:0] count);
		logic [63:0] m;
		m = ({32'd0, magnitude(count)} * {32'd0, angle_gain_cfg} + 64'd32768) >> 16;
		return count[31] ? ~m[47:0] + 48'd1 : m[47:0];
	endfunction

	function automatic meter_reading_t apply_event(input encoder_event_t ev);
		meter_reading_t r;
		if (ev.func == FUNC_TICK) begin
			speed_q8 = rpm_from_delta(count_now - count_at_tick);
			count_at_tick = count_now;
		end else begin
			count_now = ev.b_level ? count_now - 32'd1 : count_now + 32'd1;
		end
		r.position = count_now;
		r.speed_rpm = speed_q8;
		r.angle_centideg = centideg_from_count(count_now);
		return r;
	endfunction

	task automatic check_field(input string name, input logic signed [47:0] want,
		input logic signed [47:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// event driver
	always @(negedge clk) begin
		if (!evt.valid || evt_taken) begin
			evt_taken = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
				evt.valid <= 1'b0;
			end else if (pending_events.size() == 0) begin
				evt.valid <= 1'b0;
			end else begin
				evt.valid <= 1'b1;
				evt.func <= pending_events[0].func;
				evt.b_level <= pending_events[0].b_level;
				if (idling && $urandom_range(0, 5) == 0)
					send_gap = $urandom_range(1, 12);
			end
		end
	end

	// result sink
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off--;
			res.ready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap--;
			res.ready <= 1'b0;
		end else begin
			res.ready <= 1'b1;
			if (idling && $urandom_range(0, 6) == 0)
				sink_gap = $urandom_range(1, 12);
		end
	end

	// beat monitor
	always @(posedge clk) begin
		meter_reading_t want;
		if (res.valid && res.ready) begin
			if (readings_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, got position %0d", $time,
					res.position);
				errors++;
			end else begin
				want = readings_due.pop_front();
				check_field("position", want.position, res.position);
				check_field("speed_rpm", want.speed_rpm, res.speed_rpm);
				check_field("angle_centideg", want.angle_centideg, res.angle_centideg);
				readings_checked++;
			end
		end
		if (evt.valid && evt.ready) begin
			readings_due.push_back(apply_event(pending_events.pop_front()));
			evt_taken = 1'b1;
			events_taken++;
		end
	end

	task automatic queue_event(input logic func, input logic b_level, input int unsigned n = 1);
		encoder_event_t ev;
		ev.func = func;
		ev.b_level = b_level;
		repeat (n) pending_events.push_back(ev);
	endtask

	task automatic queue_random(input int unsigned n, input int unsigned fwd_pct);
		encoder_event_t ev;
		repeat (n) begin
			ev.func = ($urandom_range(0, 9) == 0) ? FUNC_TICK : FUNC_EDGE;
			ev.b_level = ($urandom_range(1, 100) > fwd_pct);
			pending_events.push_back(ev);
		end
	endtask

	task automatic wait_drained();
		while (pending_events.size() != 0 || readings_due.size() != 0)
			@(posedge clk);
	endtask

	// write then read back one gain register
	task automatic set_gain(input logic idx, input logic [31:0] value);
		logic [31:0] want;
		want = (idx == REG_RPM_GAIN) ? {8'd0, value[23:0]} : value;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want) begin
			$display("%0t: readback mismatch at 0x%0h, expected 0x%0h, got 0x%0h", $time,
				{idx, 2'b00}, want, prdata);
			errors++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_RPM_GAIN)
			rpm_gain_cfg = value[23:0];
		else
			angle_gain_cfg = value;
	endtask

	task automatic set_gains(input logic [23:0] rpm, input logic [31:0] angle);
		set_gain(REG_RPM_GAIN, {8'd0, rpm});
		set_gain(REG_ANGLE_GAIN, angle);
		gain_settings++;
	endtask

	task automatic run_phase(input logic [23:0] rpm, input logic [31:0] angle,
		input int unsigned n, input bit idle_on, input int unsigned stall);
		set_gains(rpm, angle);
		idling = idle_on;
		if (stall != 0) begin
			@(posedge clk);
			hold_off = stall;
		end
		queue_random(n, $urandom_range(15, 85));
		wait_drained();
	endtask

	initial begin
		evt.valid = 1'b0;
		evt.func = FUNC_EDGE;
		evt.b_level = 1'b0;
		res.ready = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// reset gains: first tick against zero, both directions, held speed
		queue_event(FUNC_TICK, 1'b0);
		queue_event(FUNC_EDGE, 1'b0, 3);
		queue_event(FUNC_EDGE, 1'b1);
		queue_event(FUNC_TICK, 1'b0);
		queue_event(FUNC_EDGE, 1'b1, 5);
		queue_event(FUNC_TICK, 1'b1);
		queue_event(FUNC_TICK, 1'b0);
		wait_drained();

		// zero gains
		set_gains(24'd0, 32'd0);
		queue_event(FUNC_EDGE, 1'b1);
		queue_event(FUNC_EDGE, 1'b0);
		queue_event(FUNC_TICK, 1'b0);
		wait_drained();

		// full-scale gains
		set_gains(24'hff_ffff, 32'hffff_ffff);
		queue_event(FUNC_EDGE, 1'b0, 2);
		queue_event(FUNC_TICK, 1'b1);
		wait_drained();

		run_phase(24'hff_ffff, 32'hffff_ffff, 300, 1'b1, 0);
		run_phase(24'd1, 32'd1, 300, 1'b1, 200);
		run_phase(24'd0, 32'd0, 250, 1'b1, 0);
		run_phase(24'($urandom_range(0, 24'hff_ffff)), $urandom, 300, 1'b1, 0);
		run_phase(RPM_GAIN_RST, ANGLE_GAIN_RST, 300, 1'b1, 0);

		// large swings both ways, count ends 50 below where it started
		set_gains(24'hff_ffff, $urandom);
		idling = 1'b0;
		queue_event(FUNC_TICK, 1'b0);
		queue_event(FUNC_EDGE, 1'b0, 40);
		queue_event(FUNC_TICK, 1'b0);
		queue_event(FUNC_EDGE, 1'b1, 90);
		queue_event(FUNC_TICK, 1'b0);
		wait_drained();

		run_phase(24'($urandom_range(0, 24'hff_ffff)), $urandom, 300, 1'b0, 0);

		repeat (20) @(posedge clk);
		$display("%0d events and %0d results checked over %0d gain settings,", events_taken,
			readings_checked, gain_settings);
		$display("including zero and full-scale gains, large swings and a long output stall");
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#(10_000_000);
		$display("Verification failed");
		$finish;
	end

endmodule
